### rtl/bisrf_pkg.sv
// ----------------------------------------------------------------------------
// bisrf_pkg: shared types and constants for the quartic bisection root finder
// Beat structs, sequencer and phase encodings, status codes, datapath widths.
// ----------------------------------------------------------------------------
package bisrf_pkg;

  // Field widths
  localparam int X_W    = 24;   // bracket ends and midpoint, signed
  localparam int F_W    = 32;   // polynomial value, signed
  localparam int IT_W   = 6;    // halving count
  localparam int ST_W   = 2;    // status code
  localparam int EPS_W  = 21;   // tolerance register

  // Shared multiplier: 41-bit clamped Horner term split in two halves
  localparam int LIM_W  = 41;   // holds +-2^39
  localparam int SPLIT  = 21;   // low half width
  localparam int MA_W   = 22;   // multiplier A operand, signed
  localparam int P_W    = MA_W + X_W;
  localparam int FULL_W = 64;   // full Horner product

  localparam logic [EPS_W-1:0] EPS_RESET = 21'd1049;
  localparam logic signed [F_W-1:0] VAL_LIM = 32'sd2097152000;

  // Status codes
  localparam logic [ST_W-1:0] STAT_CONV = 2'd0;
  localparam logic [ST_W-1:0] STAT_BAD  = 2'd1;
  localparam logic [ST_W-1:0] STAT_CAP  = 2'd2;

  typedef struct packed {
    logic signed [X_W-1:0] interval_low;
    logic signed [X_W-1:0] interval_high;
  } in_beat_t;

  typedef struct packed {
    logic signed [X_W-1:0] root;
    logic signed [F_W-1:0] root_value;
    logic [IT_W-1:0]       iterations;
    logic [ST_W-1:0]       status;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DECIDE,
    ST_DONE
  } state_t;

  // Which point the current polynomial evaluation belongs to
  typedef enum logic [1:0] {
    PH_FA,
    PH_FB,
    PH_FC
  } phase_t;

endpackage

### rtl/bisection_root_finder_quartic_top.sv
// ----------------------------------------------------------------------------
// bisection_root_finder_quartic_top: bisection search on x^4+2x^3-7x^2+3
// Fixed-point bracket in, one root estimate out, one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat is a bracket [interval_low, interval_high] in signed
//           fixed point (FRAC_BITS fraction bits). Taken when in_valid is
//           high and in_stall low; in_stall stays high while a bracket is
//           being worked on.
//   out_* : one beat per bracket: root, f(root), halving count, status
//           (converged / bad bracket / iteration cap). Held in an output
//           register, so a new bracket is taken while a result still waits.
//   cfg_* : cfg_we writes cfg_wdata into the epsilon tolerance. Write only
//           while the block is idle.
// Sequence: every f(x) takes an init add, three Horner multiplies (each a
//   low-half and a high-half pass on the one 22x24 multiplier) and a decide.
//   f(low) and f(high) come first, then one f(mid) per halving step, then
//   the result is handed off. A bad bracket ends after f(high); at most
//   MAX_ITER halvings are done. One bracket is worked on at a time; the
//   next is taken once the sequencer is back in idle. The multiplier paces it.
// Reset: sequencer returns to idle, output beat dropped, epsilon -> ~0.001.
// Stall: a finished result waits in the done state until the output
//   register frees up; the input side keeps stalling until then.
// ----------------------------------------------------------------------------
module bisection_root_finder_quartic_top #(
  parameter int MAX_ITER  = 40,
  parameter int FRAC_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  bisrf_pkg::in_beat_t         in_data,

  output logic                        out_valid,
  input  logic                        out_stall,
  output bisrf_pkg::out_beat_t        out_data,

  input  logic                        cfg_we,
  input  logic [bisrf_pkg::EPS_W-1:0] cfg_wdata
);

  localparam int X_W    = bisrf_pkg::X_W;
  localparam int F_W    = bisrf_pkg::F_W;
  localparam int IT_W   = bisrf_pkg::IT_W;
  localparam int LIM_W  = bisrf_pkg::LIM_W;
  localparam int SPLIT  = bisrf_pkg::SPLIT;
  localparam int MA_W   = bisrf_pkg::MA_W;
  localparam int P_W    = bisrf_pkg::P_W;
  localparam int FULL_W = bisrf_pkg::FULL_W;

  // Horner term width after the fraction shift, with room for the constants
  // and for the +-2^39 clamp bound.
  localparam int T_W = (FULL_W + 1 - FRAC_BITS > LIM_W + 1) ?
                       (FULL_W + 1 - FRAC_BITS) : (LIM_W + 1);

  localparam logic signed [T_W-1:0]   K7     = T_W'(7) << FRAC_BITS;
  localparam logic signed [T_W-1:0]   K3     = T_W'(3) << FRAC_BITS;
  localparam logic signed [LIM_W-1:0] K2     = LIM_W'(2) << FRAC_BITS;
  localparam logic signed [T_W-1:0]   IN_LIM = T_W'(1) << (LIM_W - 2);
  localparam logic signed [T_W-1:0]   VLIM_T = T_W'(bisrf_pkg::VAL_LIM);
  localparam logic [IT_W-1:0]         CAP    = IT_W'(MAX_ITER);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  bisrf_pkg::state_t state_r, state_nxt;
  bisrf_pkg::phase_t phase_r, phase_nxt;

  logic [bisrf_pkg::EPS_W-1:0] eps_r;

  logic signed [X_W-1:0]   a_r, a_nxt;      // bracket end carrying fa
  logic signed [X_W-1:0]   b_r, b_nxt;
  logic signed [X_W-1:0]   x_r, x_nxt;      // point under evaluation
  logic signed [F_W-1:0]   fa_r, fa_nxt;
  logic signed [F_W-1:0]   f_r, f_nxt;      // f(x_r) once evaluated
  logic signed [LIM_W-1:0] t_r, t_nxt;      // clamped Horner term
  logic signed [P_W-1:0]   lo_r, lo_nxt;    // low-half partial product
  logic [1:0]              step_r, step_nxt;
  logic [IT_W-1:0]         it_r, it_nxt;
  bisrf_pkg::out_beat_t    res_r, res_nxt;

  logic                    out_valid_r, out_valid_nxt;
  bisrf_pkg::out_beat_t    out_data_r, out_data_nxt;

  // --------------------------------------------------------------------------
  // Shared multiplier: clamped term times x, low half then high half
  // --------------------------------------------------------------------------
  logic signed [MA_W-1:0]   mul_a;
  logic signed [P_W-1:0]    prod;
  logic signed [FULL_W-1:0] full;
  logic signed [FULL_W-1:0] shifted;
  logic signed [T_W-1:0]    kadd;
  logic signed [T_W-1:0]    t_sum;
  logic signed [LIM_W-1:0]  t_clamp;
  logic signed [F_W-1:0]    f_clamp;

  always_comb begin
    if (state_r == bisrf_pkg::ST_MUL_HI) begin
      // high half carries the sign
      mul_a = MA_W'($signed(t_r[LIM_W-1:SPLIT]));
    end else begin
      mul_a = $signed({1'b0, t_r[SPLIT-1:0]});
    end
  end

  assign prod    = mul_a * x_r;
  assign full    = FULL_W'(lo_r) + (FULL_W'(prod) <<< SPLIT);
  assign shifted = full >>> FRAC_BITS;   // floor

  always_comb begin
    unique case (step_r)
      2'd0:    kadd = -K7;
      2'd2:    kadd = K3;
      default: kadd = '0;
    endcase
  end

  assign t_sum = T_W'(shifted) + kadd;

  always_comb begin
    priority if (t_sum > IN_LIM) begin
      t_clamp = LIM_W'(IN_LIM);
    end else if (t_sum < -IN_LIM) begin
      t_clamp = LIM_W'(-IN_LIM);
    end else begin
      t_clamp = LIM_W'(t_sum);
    end
  end

  always_comb begin
    priority if (t_sum > VLIM_T) begin
      f_clamp = bisrf_pkg::VAL_LIM;
    end else if (t_sum < -VLIM_T) begin
      f_clamp = -bisrf_pkg::VAL_LIM;
    end else begin
      f_clamp = F_W'(t_sum);
    end
  end

  // --------------------------------------------------------------------------
  // Decision terms
  // --------------------------------------------------------------------------
  logic signed [X_W:0]   mid_sum;
  logic signed [X_W-1:0] mid;
  logic [F_W-1:0]        abs_f;
  logic                  bad_bracket;
  logic                  converged;
  logic [IT_W-1:0]       it_inc;
  logic                  at_cap;

  assign mid_sum     = (X_W+1)'(a_r) + (X_W+1)'(b_r);
  assign mid         = X_W'(mid_sum >>> 1);
  assign abs_f       = f_r[F_W-1] ? F_W'(-f_r) : F_W'(f_r);
  // fa * fb >= 0: a zero at either end, or matching signs
  assign bad_bracket = (fa_r == '0) || (f_r == '0) || (fa_r[F_W-1] == f_r[F_W-1]);
  assign converged   = (f_r == '0) || (abs_f < F_W'(eps_r));
  assign it_inc      = it_r + IT_W'(1);
  assign at_cap      = (it_inc == CAP);

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bisrf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = bisrf_pkg::ST_INIT;
      end
      bisrf_pkg::ST_INIT:   state_nxt = bisrf_pkg::ST_MUL_LO;
      bisrf_pkg::ST_MUL_LO: state_nxt = bisrf_pkg::ST_MUL_HI;
      bisrf_pkg::ST_MUL_HI: begin
        state_nxt = (step_r == 2'd2) ? bisrf_pkg::ST_DECIDE : bisrf_pkg::ST_MUL_LO;
      end
      bisrf_pkg::ST_DECIDE: begin
        unique case (phase_r)
          bisrf_pkg::PH_FA: state_nxt = bisrf_pkg::ST_INIT;
          bisrf_pkg::PH_FB: begin
            state_nxt = bad_bracket ? bisrf_pkg::ST_DONE : bisrf_pkg::ST_INIT;
          end
          default: begin
            state_nxt = (converged || at_cap) ? bisrf_pkg::ST_DONE : bisrf_pkg::ST_INIT;
          end
        endcase
      end
      bisrf_pkg::ST_DONE: begin
        if (out_free) state_nxt = bisrf_pkg::ST_IDLE;
      end
      default: state_nxt = bisrf_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: datapath updates
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt     = phase_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    x_nxt         = x_r;
    fa_nxt        = fa_r;
    f_nxt         = f_r;
    t_nxt         = t_r;
    lo_nxt        = lo_r;
    step_nxt      = step_r;
    it_nxt        = it_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      bisrf_pkg::ST_IDLE: begin
        if (in_valid) begin
          a_nxt     = in_data.interval_low;
          b_nxt     = in_data.interval_high;
          x_nxt     = in_data.interval_low;
          phase_nxt = bisrf_pkg::PH_FA;
        end
      end
      bisrf_pkg::ST_INIT: begin
        // bisection steps pick up the fresh midpoint here
        if (phase_r == bisrf_pkg::PH_FC) begin
          x_nxt = mid;
          t_nxt = LIM_W'(mid) + K2;
        end else begin
          t_nxt = LIM_W'(x_r) + K2;
        end
        step_nxt = 2'd0;
      end
      bisrf_pkg::ST_MUL_LO: begin
        lo_nxt = prod;
      end
      bisrf_pkg::ST_MUL_HI: begin
        if (step_r == 2'd2) begin
          f_nxt = f_clamp;
        end else begin
          t_nxt    = t_clamp;
          step_nxt = step_r + 2'd1;
        end
      end
      bisrf_pkg::ST_DECIDE: begin
        unique case (phase_r)
          bisrf_pkg::PH_FA: begin
            fa_nxt    = f_r;
            x_nxt     = b_r;
            phase_nxt = bisrf_pkg::PH_FB;
          end
          bisrf_pkg::PH_FB: begin
            it_nxt    = '0;
            phase_nxt = bisrf_pkg::PH_FC;
            res_nxt   = '{root: '0, root_value: '0, iterations: '0,
                          status: bisrf_pkg::STAT_BAD};
          end
          default: begin
            it_nxt = it_inc;
            res_nxt = '{root: x_r, root_value: f_r, iterations: it_inc,
                        status: converged ? bisrf_pkg::STAT_CONV : bisrf_pkg::STAT_CAP};
            if (fa_r[F_W-1] != f_r[F_W-1]) begin
              b_nxt = x_r;
            end else begin
              a_nxt  = x_r;
              fa_nxt = f_r;
            end
          end
        endcase
      end
      bisrf_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flops
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bisrf_pkg::ST_IDLE;
      phase_r     <= bisrf_pkg::PH_FA;
      out_valid_r <= 1'b0;
      eps_r       <= bisrf_pkg::EPS_RESET;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) eps_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    x_r        <= x_nxt;
    fa_r       <= fa_nxt;
    f_r        <= f_nxt;
    t_r        <= t_nxt;
    lo_r       <= lo_nxt;
    step_r     <= step_nxt;
    it_r       <= it_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != bisrf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("bracket accepted but block not busy");

  a_bad_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == bisrf_pkg::STAT_BAD |->
      out_data.root == '0 && out_data.root_value == '0 && out_data.iterations == '0)
    else $error("bad bracket result not zeroed");

  a_cap_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == bisrf_pkg::STAT_CAP |-> out_data.iterations == CAP)
    else $error("cap status with wrong halving count");

  a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == bisrf_pkg::STAT_CONV |->
      out_data.iterations != '0 && out_data.iterations <= CAP)
    else $error("converged result with impossible halving count");

  a_load_only_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == bisrf_pkg::ST_DONE)
    else $error("result beat raised outside done state");

endmodule
